FILE: design/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the sorted key table: depth, field widths,
// operation and status codes, and the structs passed between the modules.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int PRICE_W     = 32;

    localparam logic [KEY_W-1:0] RESET_KEY = 32'd7000000;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_MISS     = 3'd2,
        ST_FULL     = 3'd3,
        ST_RESERVED = 3'd4
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
    } t_entry;

    typedef struct packed {
        t_status status;
        t_addr   position;
        t_entry  entry;
        t_cnt    used;
    } t_result;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_entry wdata;
        t_addr  raddr;
    } t_mem_req;

endpackage

FILE: design/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of up to 64 key/price entries kept sorted by unsigned key.
//
// Input channel: i_in_valid with o_in_stall; one word carries operation,
// key, price and position. Output channel: o_out_valid with i_out_stall;
// one result word per input word (status, position, entry, entries used).
// The reserved key register is written through i_cfg_we / i_cfg_data;
// the user must do so only while the block is idle; the block does not check.
// One operation runs at a time; o_in_stall is high until the sequencer is
// back in idle. A find or insert runs a binary search of up to 7 probes,
// each a RAM read followed by a compare. Insert then moves entries up
// one slot per cycle from the end down to the insert point, delete moves
// them down one per cycle; each shift uses the single RAM read and write
// port. The next word is accepted only after the result has been passed
// to the output register. The output register holds a result while
// i_out_stall is high and the next word is already accepted; its result
// waits in the sequencer.
// Reset (synchronous, i_rst_n low) empties the table, restores the
// reserved key to 7000000 and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_key_table
    import skt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [PRICE_W-1:0] i_price,
    input  logic [ADDR_W-1:0]  i_position,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [ADDR_W-1:0]  o_found_position,
    output logic [KEY_W-1:0]   o_entry_key,
    output logic [PRICE_W-1:0] o_entry_price,
    output logic [CNT_W-1:0]   o_entries_used,
    input  logic               i_cfg_we,
    input  logic [KEY_W-1:0]   i_cfg_data
);

    logic [KEY_W-1:0] r_reserved_key;
    logic             r_out_valid;
    t_result          r_out;

    logic             seq_idle;
    logic             res_valid;
    logic             res_take;
    t_result          res;
    t_mem_req         mem_req;
    t_entry           rd_data;

    assign o_in_stall = !seq_idle;
    assign res_take   = res_valid && (!r_out_valid || !i_out_stall);

    skt_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_in_valid && seq_idle),
        .i_operation    (t_op'(i_operation)),
        .i_key          (i_key),
        .i_price        (i_price),
        .i_position     (i_position),
        .i_reserved_key (r_reserved_key),
        .o_idle         (seq_idle),
        .o_res_valid    (res_valid),
        .i_res_take     (res_take),
        .o_res          (res),
        .o_mem          (mem_req),
        .i_rd_data      (rd_data)
    );

    skt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved_key <= RESET_KEY;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_reserved_key <= i_cfg_data;
            end
            // load a new result when the register is empty or being drained
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.position;
    assign o_entry_key      = r_out.entry.key;
    assign o_entry_price    = r_out.entry.price;
    assign o_entries_used   = r_out.used;

endmodule

FILE: design/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No reset on the contents.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/skt_seq.sv
// ----------------------------------------------------------------------------
// skt_seq
// Operation sequencer: binary search over the entry RAM with one compare
// per probe, entry shifting one word per cycle through the RAM ports,
// reads by position, and the fill count.
// ----------------------------------------------------------------------------
module skt_seq
    import skt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_op                i_operation,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [PRICE_W-1:0] i_price,
    input  t_addr              i_position,
    input  logic [KEY_W-1:0]   i_reserved_key,
    output logic               o_idle,
    output logic               o_res_valid,
    input  logic               i_res_take,
    output t_result            o_res,
    output t_mem_req           o_mem,
    input  t_entry             i_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SRCH,
        S_SRCH_CMP,
        S_SH_UP,
        S_INS_WR,
        S_SH_DN,
        S_RD_CAP,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [PRICE_W-1:0] r_price, n_price;
    t_addr              r_pos, n_pos;
    t_cnt               r_fill, n_fill;
    t_cnt               r_lo, n_lo;
    t_cnt               r_hi, n_hi;
    t_addr              r_mid, n_mid;
    t_cnt               r_ptr, n_ptr;
    t_addr              r_wa, n_wa;
    logic               r_pend, n_pend;
    logic               r_cap, n_cap;
    t_result            r_res, n_res;

    t_cnt               mid_full;
    t_cnt               pos_ext;
    t_cnt               ptr_dec;

    assign mid_full = r_lo + ((r_hi - r_lo) >> 1);
    assign pos_ext  = {1'b0, r_pos};
    assign ptr_dec  = r_ptr - t_cnt'(1);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_key   = r_key;
        n_price = r_price;
        n_pos   = r_pos;
        n_fill  = r_fill;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_ptr   = r_ptr;
        n_wa    = r_wa;
        n_pend  = r_pend;
        n_cap   = r_cap;
        n_res   = r_res;

        o_mem.we    = 1'b0;
        o_mem.waddr = r_wa;
        o_mem.wdata = i_rd_data;
        o_mem.raddr = r_mid;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_operation;
                    n_key   = i_key;
                    n_price = i_price;
                    n_pos   = i_position;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_res = '{status: ST_MISS, position: '0, entry: '0, used: r_fill};
                n_lo  = '0;
                n_hi  = r_fill;
                unique case (r_op)
                    OP_INSERT: begin
                        n_state = S_SRCH;
                    end
                    OP_FIND: begin
                        if (r_key == i_reserved_key) begin
                            n_res.status = ST_RESERVED;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_SRCH;
                        end
                    end
                    OP_DELETE: begin
                        if (pos_ext < r_fill) begin
                            n_ptr   = pos_ext;
                            n_pend  = 1'b0;
                            n_cap   = 1'b0;
                            n_state = S_SH_DN;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_READ: begin
                        if (pos_ext < r_fill) begin
                            o_mem.raddr = r_pos;
                            n_state     = S_RD_CAP;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    o_mem.raddr = mid_full[ADDR_W-1:0];
                    n_mid       = mid_full[ADDR_W-1:0];
                    n_state     = S_SRCH_CMP;
                end else if (r_op == OP_INSERT) begin
                    if (r_fill == t_cnt'(TABLE_DEPTH)) begin
                        n_res.status = ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_ptr   = r_fill;
                        n_pend  = 1'b0;
                        n_state = S_SH_UP;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SRCH_CMP: begin
                if (i_rd_data.key == r_key) begin
                    n_res.status   = (r_op == OP_INSERT) ? ST_DUP : ST_OK;
                    n_res.position = r_mid;
                    n_res.entry    = i_rd_data;
                    n_state        = S_DONE;
                end else begin
                    if (i_rd_data.key > r_key) begin
                        n_hi = {1'b0, r_mid};
                    end else begin
                        n_lo = {1'b0, r_mid} + t_cnt'(1);
                    end
                    n_state = S_SRCH;
                end
            end
            S_SH_UP: begin
                // r_lo holds the insertion point; move entries up one slot
                o_mem.we = r_pend;
                if (r_ptr > r_lo) begin
                    o_mem.raddr = ptr_dec[ADDR_W-1:0];
                    n_wa        = r_ptr[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_ptr       = ptr_dec;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_mem.we       = 1'b1;
                o_mem.waddr    = r_lo[ADDR_W-1:0];
                o_mem.wdata    = '{key: r_key, price: r_price};
                n_fill         = r_fill + t_cnt'(1);
                n_res.status   = ST_OK;
                n_res.position = r_lo[ADDR_W-1:0];
                n_res.entry    = '{key: r_key, price: r_price};
                n_res.used     = r_fill + t_cnt'(1);
                n_state        = S_DONE;
            end
            S_SH_DN: begin
                // first word read is the removed entry, later ones move down
                o_mem.we = r_pend;
                if (r_cap) begin
                    n_res.entry = i_rd_data;
                end
                if (r_ptr < r_fill) begin
                    o_mem.raddr = r_ptr[ADDR_W-1:0];
                    n_wa        = ptr_dec[ADDR_W-1:0];
                    n_cap       = (r_ptr == pos_ext);
                    n_pend      = (r_ptr != pos_ext);
                    n_ptr       = r_ptr + t_cnt'(1);
                end else begin
                    n_pend         = 1'b0;
                    n_cap          = 1'b0;
                    n_fill         = r_fill - t_cnt'(1);
                    n_res.status   = ST_OK;
                    n_res.position = r_pos;
                    n_res.used     = r_fill - t_cnt'(1);
                    n_state        = S_DONE;
                end
            end
            S_RD_CAP: begin
                n_res.status   = ST_OK;
                n_res.position = r_pos;
                n_res.entry    = i_rd_data;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_cap   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_cap   <= n_cap;
        end
        r_op    <= n_op;
        r_key   <= n_key;
        r_price <= n_price;
        r_pos   <= n_pos;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_ptr   <= n_ptr;
        r_wa    <= n_wa;
        r_res   <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_cnt'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> (r_state == S_SH_UP || r_state == S_SH_DN || r_state == S_INS_WR))
        else $error("RAM write outside a shift or insert");

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_CMP) |-> ({1'b0, r_mid} < r_fill))
        else $error("search probe beyond valid entries");

    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |=> (r_fill == $past(r_fill)))
        else $error("fill count moved while no operation runs");

    a_done_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_res_take) |=> (r_state == S_IDLE))
        else $error("sequencer stuck after result handoff");

endmodule
